// ===== src/sem_pkg.sv =====
`default_nettype none
package sem_pkg;

  // Default frame limits for the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Field and register widths.
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int GRAD_W    = 11;
  localparam int SUM_W     = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 13'd4096;

  // Largest sum of squares whose rounded root still fits in 8 bits; larger sums clamp to 255.
  localparam logic [SUM_W-1:0] MAG_CLAMP = 21'd65280;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Input item kinds.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [2:0][SUM_W-1:0] sum3_t;
  typedef logic [2:0][CH_W-1:0]  mag3_t;

  typedef struct packed {
    logic start;
  } root_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage
`default_nettype wire

// ===== src/sem_if.sv =====
`default_nettype none
// Pixel request channel.
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source(output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink(input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

// Edge result channel.
interface sem_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_edge;
  logic [7:0] green_edge;
  logic [7:0] blue_edge;
  logic       last_of_frame;
  modport source(output valid, red_edge, green_edge, blue_edge, last_of_frame, input ready);
  modport sink(input valid, red_edge, green_edge, blue_edge, last_of_frame, output ready);
endinterface

// Configuration write channel.
interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/sobel_edge_magnitude_rgb.sv =====
// An item reads the line stores and shifts the window; one that completes a result
// then passes the sums, the eight-step square root unit and the output register.
// A new item is accepted only in the idle state, once the previous one is through.
// Reset: control state, counters and window clear at once; the line stores are
// not cleared, since reads of entries not yet written are masked by the row bounds.
`default_nettype none
module sobel_edge_magnitude_rgb #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sem_pix_if.sink    pix,
  sem_edge_if.source edges,
  sem_cfg_if.sink    cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int PW = sem_pkg::PIX_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SQ   = 4'b0100,
    ST_ROOT = 4'b1000
  } state_t;

  typedef logic [2:0][2:0][PW-1:0] win_t;
  typedef logic [2:0][2:0][7:0]    chwin_t;

  state_t state;

  logic [sem_pkg::FW_W-1:0] frame_width;
  logic [sem_pkg::FH_W-1:0] frame_height;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  win_t          win;

  logic          op_q;
  logic [PW-1:0] px_in_q;
  logic [CW-1:0] ic_q;
  logic [RW-1:0] ir_q;
  logic          restart_q;
  logic          last_q;
  logic signed [2:0][sem_pkg::GRAD_W-1:0] gx;
  logic signed [2:0][sem_pkg::GRAD_W-1:0] gy;

  logic       out_valid;
  logic [7:0] red_q, green_q, blue_q;
  logic       last_out;

  // Sobel kernels on one channel of a window.
  function automatic logic [sem_pkg::GRAD_W-1:0] sob_gx(input chwin_t p);
    logic [9:0] a;
    logic [9:0] b;
    a = 10'(p[0][2]) + 10'({p[1][2], 1'b0}) + 10'(p[2][2]);
    b = 10'(p[0][0]) + 10'({p[1][0], 1'b0}) + 10'(p[2][0]);
    return {1'b0, a} - {1'b0, b};
  endfunction

  function automatic logic [sem_pkg::GRAD_W-1:0] sob_gy(input chwin_t p);
    logic [9:0] a;
    logic [9:0] b;
    a = 10'(p[2][0]) + 10'({p[2][1], 1'b0}) + 10'(p[2][2]);
    b = 10'(p[0][0]) + 10'({p[0][1], 1'b0}) + 10'(p[0][2]);
    return {1'b0, a} - {1'b0, b};
  endfunction

  // Effective frame size.
  logic [WW-1:0] eff_w;
  logic [RW-1:0] eff_h;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = RW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(frame_height);
    end
  end

  // Input side: a stray counter position restarts the frame.
  logic          accept;
  logic          restart_now;
  logic [CW-1:0] ic_now;
  logic [RW-1:0] ir_now;

  assign pix.ready   = (state == ST_IDLE);
  assign accept      = pix.valid && pix.ready;
  assign restart_now = (WW'(in_col) >= eff_w)
                    || ({1'b0, in_row} > {1'b0, eff_h} + (RW+1)'(1));
  assign ic_now      = restart_now ? '0 : in_col;
  assign ir_now      = restart_now ? '0 : in_row;

  // Line stores: upper row in the top half, middle row in the bottom half.
  logic [2*PW-1:0] ram_rdata;
  logic [PW-1:0]   upper_old, middle_old;
  logic            ram_we;
  logic [PW-1:0]   px;

  assign upper_old  = ram_rdata[2*PW-1:PW];
  assign middle_old = ram_rdata[PW-1:0];
  assign ram_we     = (state == ST_READ);

  sem_ram #(
    .WIDTH(2 * PW),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ic_q),
    .wdata({middle_old, px}),
    .re   (accept),
    .raddr(ic_now),
    .rdata(ram_rdata)
  );

  // Row bounds of the current request.
  logic [RW:0] ir_x, h_x;
  logic        top_ok, mid_ok, px_ok;
  logic [PW-1:0] top, mid;

  assign ir_x   = {1'b0, ir_q};
  assign h_x    = {1'b0, eff_h};
  assign top_ok = (ir_x >= (RW+1)'(2)) && (ir_x < h_x + (RW+1)'(2));
  assign mid_ok = (ir_x >= (RW+1)'(1)) && (ir_x < h_x + (RW+1)'(1));
  assign px_ok  = (op_q == sem_pkg::OP_PIXEL) && (ir_x < h_x);
  assign px     = px_ok ? px_in_q : '0;
  assign top    = top_ok ? upper_old : '0;
  assign mid    = mid_ok ? middle_old : '0;

  // Window shift and choice of the window that yields the result.
  win_t          win_base, win_shift, win_src;
  logic          emit, zl, zr, last_now;
  logic [CW-1:0] oc_base;
  logic [RW-1:0] or_base;

  always_comb begin
    win_base = restart_q ? '0 : win;
    for (int i = 0; i < 3; i++) begin
      win_shift[i][0] = win_base[i][1];
      win_shift[i][1] = win_base[i][2];
    end
    win_shift[0][2] = top;
    win_shift[1][2] = mid;
    win_shift[2][2] = px;

    if (ic_q == '0) begin
      emit    = top_ok;
      zl      = (eff_w == WW'(1));
      zr      = 1'b1;
      win_src = win_base;
    end else begin
      emit    = mid_ok;
      zl      = (ic_q == CW'(1));
      zr      = 1'b0;
      win_src = win_shift;
    end
    for (int i = 0; i < 3; i++) begin
      if (zl) begin
        win_src[i][0] = '0;
      end
      if (zr) begin
        win_src[i][2] = '0;
      end
    end

    oc_base  = restart_q ? '0 : out_col;
    or_base  = restart_q ? '0 : out_row;
    last_now = emit && (WW'(oc_base) == eff_w - WW'(1)) && (or_base == eff_h - RW'(1));
  end

  // Gradients of the three channels.
  chwin_t [2:0] chwin;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          chwin[k][i][j] = win_src[i][j][PW-1-8*k -: 8];
        end
      end
    end
  end

  // Sums of squares handed to the root unit; gradients are sign-extended first.
  sem_pkg::sum3_t      sums;
  sem_pkg::mag3_t      mags;
  sem_pkg::root_req_t  root_req;
  sem_pkg::root_stat_t root_stat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sums[k] = sem_pkg::SUM_W'($unsigned(22'($signed(gx[k])) * 22'($signed(gx[k]))))
              + sem_pkg::SUM_W'($unsigned(22'($signed(gy[k])) * 22'($signed(gy[k]))));
    end
  end

  assign root_req.start = (state == ST_SQ);

  sem_root u_root (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .sums(sums),
    .stat(root_stat),
    .mags(mags)
  );

  logic load_out;
  assign load_out = (state == ST_ROOT) && root_stat.done && (!out_valid || edges.ready);

  // Sequencer, configuration and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      frame_width  <= sem_pkg::FW_RESET;
      frame_height <= sem_pkg::FH_RESET;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      win          <= '0;
      restart_q    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        sem_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg.data[sem_pkg::FW_W-1:0];
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
          win     <= '0;
        end
        sem_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg.data;
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
          win     <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            restart_q <= restart_now;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          if (last_now) begin
            win     <= '0;
            in_col  <= '0;
            in_row  <= '0;
            out_col <= '0;
            out_row <= '0;
          end else begin
            win <= win_shift;
            if (WW'(ic_q) + WW'(1) >= eff_w) begin
              in_col <= '0;
              in_row <= ir_q + RW'(1);
            end else begin
              in_col <= ic_q + CW'(1);
              in_row <= ir_q;
            end
            if (emit) begin
              if (WW'(oc_base) + WW'(1) >= eff_w) begin
                out_col <= '0;
                out_row <= or_base + RW'(1);
              end else begin
                out_col <= oc_base + CW'(1);
                out_row <= or_base;
              end
            end else begin
              out_col <= oc_base;
              out_row <= or_base;
            end
          end
          state <= emit ? ST_SQ : ST_IDLE;
        end
        ST_SQ: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Request and gradient registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= pix.operation;
      px_in_q <= {pix.red_in, pix.green_in, pix.blue_in};
      ic_q    <= ic_now;
      ir_q    <= ir_now;
    end
    if (state == ST_READ) begin
      last_q <= last_now;
      for (int k = 0; k < 3; k++) begin
        gx[k] <= sob_gx(chwin[k]);
        gy[k] <= sob_gy(chwin[k]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (edges.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red_q    <= mags[0];
      green_q  <= mags[1];
      blue_q   <= mags[2];
      last_out <= last_q;
    end
  end

  assign edges.valid         = out_valid;
  assign edges.red_edge      = red_q;
  assign edges.green_edge    = green_q;
  assign edges.blue_edge     = blue_q;
  assign edges.last_of_frame = last_out;

  // The root unit starts on every request that yields a result.
  a_root_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |=> root_stat.busy)
    else $error("root unit did not start");

  // A request without a result frees the input at once.
  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && !emit && !cfg.valid) |=> (state == ST_IDLE))
    else $error("request without result did not return to idle");

  // The frame's final result clears all position counters.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && last_now && !cfg.valid)
      |=> (in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0))
    else $error("counters not cleared after end of frame");

  // A result is only ever loaded when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !edges.ready) |=> out_valid && $stable(red_q))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== src/sem_ram.sv =====
`default_nettype none
// Simple dual-port RAM with a registered read.
module sem_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/sem_root.sv =====
`default_nettype none
// Rounded square root for three channels, one result bit per cycle.
// Finds the largest m with m*(m-1) < s, clamped to 255.
module sem_root (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sem_pkg::root_req_t req,
  input  wire sem_pkg::sum3_t     sums,
  output sem_pkg::root_stat_t     stat,
  output sem_pkg::mag3_t          mags
);

  sem_pkg::sum3_t sq;
  sem_pkg::mag3_t m;
  logic [2:0]     bitpos;
  logic           busy;
  logic           done;

  // Trial values for the current bit.
  logic [2:0][7:0]  cand;
  logic [2:0][15:0] prod;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cand[k] = m[k] | (8'd1 << bitpos);
      prod[k] = {8'd0, cand[k]} * {8'd0, cand[k] - 8'd1};
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && bitpos == 3'd0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      sq     <= sums;
      m      <= '0;
      bitpos <= 3'd7;
    end else if (busy) begin
      bitpos <= bitpos - 3'd1;
      for (int k = 0; k < 3; k++) begin
        if (sq[k] > sem_pkg::MAG_CLAMP) begin
          m[k] <= 8'hFF;
        end else if ({5'd0, prod[k]} < sq[k]) begin
          m[k] <= cand[k];
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign mags      = m;

endmodule
`default_nettype wire
